/* hw/rtl/ardf_pkg.sv */
// Shared constants, codes and the result record of the ar archive deframer.
package ardf_pkg;

   // Archive layout
   localparam int unsigned MAGIC_LEN = 8;
   localparam int unsigned HDR_LEN   = 60;
   localparam int unsigned NAME_LEN  = 16;
   localparam int unsigned SIZE_OFF  = 48;
   localparam int unsigned END_OFF   = 58;

   localparam int unsigned POS_W  = 6;
   localparam int unsigned SIZE_W = 34;
   localparam int unsigned LEN_W  = 5;
   localparam int unsigned IDX_W  = 16;

   // Characters of interest
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_BQUOTE  = 8'h60;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Request operations
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_CONTENT = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_MAGIC     = 3'd0;
   localparam logic [2:0] ERR_ENDING    = 3'd1;
   localparam logic [2:0] ERR_SIZE      = 3'd2;
   localparam logic [2:0] ERR_PADDING   = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        error_code;
      logic [63:0]       name_front;
      logic [63:0]       name_back;
      logic [LEN_W-1:0]  name_length;
      logic [SIZE_W-1:0] member_size;
      logic [IDX_W-1:0]  member_index;
      logic [7:0]        content_byte;
      logic              last_in_member;
   } result_type;

   // Global archive magic "!<arch>\n"
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h21;
         3'd1:    val = 8'h3C;
         3'd2:    val = 8'h61;
         3'd3:    val = 8'h72;
         3'd4:    val = 8'h63;
         3'd5:    val = 8'h68;
         3'd6:    val = 8'h3E;
         default: val = 8'h0A;
      endcase
      return val;
   endfunction

endpackage

/* hw/rtl/ardf_core.sv */
// Parse engine: magic check, header fields, content counting and padding.
module ardf_core import ardf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       accept,
   input  logic       op,
   input  logic [7:0] data_byte,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [4:0] {
      PH_MAGIC   = 5'b00001,
      PH_HEADER  = 5'b00010,
      PH_CONTENT = 5'b00100,
      PH_PAD     = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        name_ff [NAME_LEN];
   logic [SIZE_W-1:0] acc_ff, acc_in;
   logic              digits_done_ff, digits_done_in;
   logic              size_bad_ff, size_bad_in;
   logic              ending_bad_ff, ending_bad_in;
   logic [SIZE_W-1:0] remain_ff, remain_in;
   logic [IDX_W-1:0]  member_ff, member_in;
   logic [LEN_W-1:0]  trim_end_ff, trim_end_in;
   logic              trim_slash_ff, trim_slash_in;
   logic              check_pad_ff;

   logic [SIZE_W-1:0] acc_ten;
   logic [LEN_W-1:0]  name_len;
   logic              is_digit;
   logic              name_wr;
   logic [63:0]       front, back;

   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign acc_ten  = {acc_ff[SIZE_W-4:0], 3'b000} + {acc_ff[SIZE_W-2:0], 1'b0}
                   + {{(SIZE_W-4){1'b0}}, data_byte[3:0]};
   // drop one trailing slash behind the last non-space character
   assign name_len = trim_end_ff - {{(LEN_W-1){1'b0}}, trim_slash_ff};
   assign name_wr  = accept && (op == OP_BYTE) && (phase_ff == PH_HEADER)
                   && (pos_ff < POS_W'(NAME_LEN));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         front[63-8*i -: 8] = (LEN_W'(i)   < name_len) ? name_ff[i]   : 8'd0;
         back[63-8*i -: 8]  = (LEN_W'(i+8) < name_len) ? name_ff[i+8] : 8'd0;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      acc_in         = acc_ff;
      digits_done_in = digits_done_ff;
      size_bad_in    = size_bad_ff;
      ending_bad_in  = ending_bad_ff;
      remain_in      = remain_ff;
      member_in      = member_ff;
      trim_end_in    = trim_end_ff;
      trim_slash_in  = trim_slash_ff;
      res_valid      = 1'b0;
      res            = '0;

      if (accept) begin
         if (op == OP_END) begin
            if (phase_ff == PH_HEADER && pos_ff == '0) begin
               res_valid = 1'b1;
               res.kind  = KIND_END;
            end else if (phase_ff != PH_ERROR) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_TRUNCATED;
            end
            phase_in       = PH_MAGIC;
            pos_in         = '0;
            acc_in         = '0;
            digits_done_in = 1'b0;
            size_bad_in    = 1'b0;
            ending_bad_in  = 1'b0;
            remain_in      = '0;
            member_in      = '0;
         end else begin
            unique case (phase_ff)
               PH_MAGIC: begin
                  if (data_byte != magic_byte(pos_ff[2:0])) begin
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_MAGIC;
                     phase_in       = PH_ERROR;
                  end else if (pos_ff == POS_W'(MAGIC_LEN - 1)) begin
                     phase_in = PH_HEADER;
                     pos_in   = '0;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
               PH_HEADER: begin
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff < POS_W'(NAME_LEN)) begin
                     if (data_byte != CHAR_SPACE) begin
                        trim_end_in   = LEN_W'(pos_ff) + 1'b1;
                        trim_slash_in = (data_byte == CHAR_SLASH);
                     end else if (pos_ff == '0) begin
                        trim_end_in   = '0;
                        trim_slash_in = 1'b0;
                     end
                  end else if (pos_ff >= POS_W'(SIZE_OFF) && pos_ff < POS_W'(END_OFF)) begin
                     if (!digits_done_ff && !size_bad_ff) begin
                        if (is_digit)                     acc_in         = acc_ten;
                        else if (data_byte == CHAR_SPACE) digits_done_in = 1'b1;
                        else                              size_bad_in    = 1'b1;
                     end
                  end else if (pos_ff == POS_W'(END_OFF)) begin
                     if (data_byte != CHAR_BQUOTE) ending_bad_in = 1'b1;
                  end else if (pos_ff == POS_W'(HDR_LEN - 1)) begin
                     res_valid = 1'b1;
                     if (ending_bad_ff || data_byte != CHAR_NEWLINE) begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_ENDING;
                        phase_in       = PH_ERROR;
                     end else if (size_bad_ff) begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SIZE;
                        phase_in       = PH_ERROR;
                     end else begin
                        res.kind         = KIND_HEADER;
                        res.name_front   = front;
                        res.name_back    = back;
                        res.name_length  = name_len;
                        res.member_size  = acc_ff;
                        res.member_index = member_ff;
                        member_in        = member_ff + 1'b1;
                        pos_in           = '0;
                        if (acc_ff == '0) begin
                           // empty member: next byte opens the next header
                           digits_done_in = 1'b0;
                           size_bad_in    = 1'b0;
                           ending_bad_in  = 1'b0;
                        end else begin
                           phase_in  = PH_CONTENT;
                           remain_in = acc_ff;
                        end
                     end
                  end
               end
               PH_CONTENT: begin
                  res_valid          = 1'b1;
                  res.kind           = KIND_CONTENT;
                  res.content_byte   = data_byte;
                  res.last_in_member = (remain_ff == SIZE_W'(1));
                  remain_in          = remain_ff - 1'b1;
                  if (remain_ff == SIZE_W'(1)) begin
                     if (acc_ff[0]) begin
                        phase_in = PH_PAD;
                     end else begin
                        phase_in       = PH_HEADER;
                        pos_in         = '0;
                        acc_in         = '0;
                        digits_done_in = 1'b0;
                        size_bad_in    = 1'b0;
                        ending_bad_in  = 1'b0;
                     end
                  end
               end
               PH_PAD: begin
                  if (check_pad_ff && data_byte != CHAR_NEWLINE) begin
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_PADDING;
                     phase_in       = PH_ERROR;
                  end else begin
                     phase_in       = PH_HEADER;
                     pos_in         = '0;
                     acc_in         = '0;
                     digits_done_in = 1'b0;
                     size_bad_in    = 1'b0;
                     ending_bad_in  = 1'b0;
                  end
               end
               PH_ERROR: begin
                  // swallow bytes until the end marker
               end
               default: begin
                  phase_in = PH_ERROR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAGIC;
         pos_ff         <= '0;
         acc_ff         <= '0;
         digits_done_ff <= 1'b0;
         size_bad_ff    <= 1'b0;
         ending_bad_ff  <= 1'b0;
         remain_ff      <= '0;
         member_ff      <= '0;
         trim_end_ff    <= '0;
         trim_slash_ff  <= 1'b0;
         check_pad_ff   <= 1'b1;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         acc_ff         <= acc_in;
         digits_done_ff <= digits_done_in;
         size_bad_ff    <= size_bad_in;
         ending_bad_ff  <= ending_bad_in;
         remain_ff      <= remain_in;
         member_ff      <= member_in;
         trim_end_ff    <= trim_end_in;
         trim_slash_ff  <= trim_slash_in;
         if (csr_wr_en) check_pad_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (name_wr) name_ff[pos_ff[3:0]] <= data_byte;
   end

endmodule

/* hw/rtl/ardf_skid.sv */
// Result register with one skid entry so the parser keeps running under stall.
module ardf_skid import ardf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_result,
   input  logic       out_stall,
   output logic       out_valid,
   output result_type out_result,
   output logic       full
);

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;
   logic       out_take;

   assign out_take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // drain the skid entry first; no new request is taken meanwhile
         if (out_take) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = in_valid;
         out_in       = in_result;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign full       = skid_valid_ff;

endmodule

/* hw/rtl/ar_archive_stream_deframer.sv */
// Top level of the ar archive stream deframer.
//
// The deframer takes a Unix ar archive one request per cycle unless stalled; each is an
// archive byte or an end-of-input marker. It checks the global magic, parses every
// 60-byte member header (name trimmed of trailing spaces and one System V slash,
// decimal size ending at the first space, backquote-newline ending), reports the member,
// then forwards each content byte with a last marker and, after odd sizes, takes the pad
// byte (checked against newline when csr_wr_data last wrote a one, the reset value).
// An end marker on a member boundary reports end of archive, anywhere else truncation.
// The first error is reported once; later bytes are dropped until the next end marker,
// which also restarts the member count. For every accepted request the parser state
// is updated by a single pass of logic behind the request handshake and at most one
// result is produced, which lands in a result register backed by one skid entry.
// req_stall rises only while the skid entry is occupied, i.e. after the consumer has held
// rsp_stall with a result pending and a further result arrived; it is driven straight
// from a register. The configuration register may be written at any time the archive
// stream is idle.
module ar_archive_stream_deframer import ardf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [7:0]          req_data_byte,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [2:0]          rsp_error_code,
   output logic [63:0]         rsp_name_front,
   output logic [63:0]         rsp_name_back,
   output logic [LEN_W-1:0]    rsp_name_length,
   output logic [SIZE_W-1:0]   rsp_member_size,
   output logic [IDX_W-1:0]    rsp_member_index,
   output logic [7:0]          rsp_content_byte,
   output logic                rsp_last_in_member
);

   logic       accept;
   logic       res_valid;
   result_type res;
   result_type rsp;
   logic       skid_full;

   // take a request whenever the skid entry is free
   assign req_stall = skid_full;
   assign accept    = req_valid && !skid_full;

   ardf_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .op          (req_op),
      .data_byte   (req_data_byte),
      .res_valid   (res_valid),
      .res         (res)
   );

   ardf_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (res_valid),
      .in_result  (res),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_result (rsp),
      .full       (skid_full)
   );

   // unpack the result record onto the ports
   assign rsp_kind           = rsp.kind;
   assign rsp_error_code     = rsp.error_code;
   assign rsp_name_front     = rsp.name_front;
   assign rsp_name_back      = rsp.name_back;
   assign rsp_name_length    = rsp.name_length;
   assign rsp_member_size    = rsp.member_size;
   assign rsp_member_index   = rsp.member_index;
   assign rsp_content_byte   = rsp.content_byte;
   assign rsp_last_in_member = rsp.last_in_member;

endmodule

/* hw/rtl/ardf_checker.sv */
// Port-level assertions for the ar archive deframer and their bind.
module ardf_checker import ardf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_kind,
   input logic [2:0]        rsp_error_code,
   input logic [LEN_W-1:0]  rsp_name_length,
   input logic              rsp_last_in_member
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_error_code))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_last_is_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_in_member |-> rsp_kind == KIND_CONTENT)
      else $error("last marker on a non-content result");

   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == ERR_MAGIC)
      else $error("error code set on a non-error result");

   a_name_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HEADER |-> rsp_name_length <= LEN_W'(NAME_LEN))
      else $error("name length out of range");

endmodule

bind ar_archive_stream_deframer ardf_checker u_ardf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_error_code     (rsp_error_code),
   .rsp_name_length    (rsp_name_length),
   .rsp_last_in_member (rsp_last_in_member)
);
